// File: rtl/sds_pkg.sv
// Shared types, constants and register codes for the SCAN disk scheduler.
package sds_pkg;

    localparam int TRACK_BITS       = 16;
    localparam int SEEK_BITS        = 17;
    localparam int TRACKS_BITS      = 17;
    localparam int CFG_IDX_BITS     = 2;
    localparam int DEF_MAX_REQUESTS = 32;

    typedef logic [TRACK_BITS-1:0]   t_track;
    typedef logic [SEEK_BITS-1:0]    t_seek;
    typedef logic [TRACKS_BITS-1:0]  t_tracks;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DISK_TRACKS = 2'd0;
    localparam t_cfg_idx CFG_START_DIR   = 2'd1;
    localparam t_cfg_idx CFG_START_HEAD  = 2'd2;

    localparam t_tracks DISK_TRACKS_RST = 17'd200;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_SCAN,
        ST_EM_RD,
        ST_EM_SEL,
        ST_EM_MOV
    } t_state;

    typedef struct packed {
        logic   neg;
        logic   zero;
        t_track mag;
    } t_alu_res;

endpackage

// File: rtl/sds_req_if.sv
// Request channel: one pending track per word.
interface sds_req_if;
    import sds_pkg::*;

    logic   valid;
    logic   ready;
    t_track request_track;
    logic   last_request;

    modport source (output valid, output request_track, output last_request, input ready);
    modport sink   (input valid, input request_track, input last_request, output ready);
endinterface

// File: rtl/sds_res_if.sv
// Result channel: one served track per word.
interface sds_res_if;
    import sds_pkg::*;

    logic   valid;
    logic   ready;
    t_track served_track;
    t_seek  total_seek;
    logic   last_result;

    modport source (output valid, output served_track, output total_seek, output last_result,
                    input ready);
    modport sink   (input valid, input served_track, input total_seek, input last_result,
                    output ready);
endinterface

// File: rtl/scan_disk_scheduler.sv
// SCAN disk scheduler top level: request store, sequencer and result register.
// Requests are kept sorted in a RAM as they arrive: each request is written after every
// stored entry larger than it has moved up one slot (insertion shifts one entry per cycle
// through the single RAM port pair). The word marked last then splits the n stored
// requests around the start head with the shared subtractor, then serves each track
// through the read, pick and move steps, with a reversal step at the sweep turn when the
// second side has tracks, and a closing step; moves wait while the result register
// is stalled. Requests beyond MAX_REQUESTS are dropped; the last word still runs the job.
// Results of a job may still sit in the result register while the next request is taken.
module scan_disk_scheduler #(
    parameter int MAX_REQUESTS = sds_pkg::DEF_MAX_REQUESTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  sds_pkg::t_cfg_idx i_cfg_idx,
    input  sds_pkg::t_tracks  i_cfg_wdata,
    sds_req_if.sink           i_req,
    sds_res_if.source         o_res
);
    import sds_pkg::*;

    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int RW = $clog2(MAX_REQUESTS + 2);

    // configuration
    t_tracks r_disk_tracks;
    logic    r_dir;
    t_track  r_start_head;

    // sequencer
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    t_track        r_t, n_t;
    logic          r_lastq, n_lastq;
    t_track        r_head, n_head;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cntl, n_cntl;
    logic [CW-1:0] r_cnte, n_cnte;
    logic [CW-1:0] r_dn, n_dn;
    logic [CW-1:0] r_up, n_up;
    logic [RW-1:0] r_rem, n_rem;
    logic          r_endp, n_endp;
    logic          r_phup, n_phup;
    t_track        r_trk, n_trk;
    t_seek         r_seek, n_seek;

    // result register
    logic   r_ovld, n_ovld;
    t_track r_otrk, n_otrk;
    t_seek  r_oseek, n_oseek;
    logic   r_olast, n_olast;

    // datapath
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_track        ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_track        ram_rdata;
    t_track        alu_a, alu_b;
    t_alu_res      alu;

    logic                 acc;
    logic                 out_free;
    t_track               endt;
    logic [CW-1:0]        cnt_m1, j_m2, dn_m1;
    logic                 up_done, dn_done, cur_done;
    logic [SEEK_BITS:0]   seek_sum;
    t_seek                seek_nx;

    sds_ram #(.WIDTH(TRACK_BITS), .DEPTH(MAX_REQUESTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sds_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu)
    );

    assign acc      = i_req.valid && i_req.ready;
    assign out_free = !r_ovld || o_res.ready;
    assign cnt_m1   = r_count - CW'(1);
    assign j_m2     = r_j - CW'(2);
    assign dn_m1    = r_dn - CW'(1);
    assign up_done  = (r_up == r_count) && !r_endp;
    assign dn_done  = (r_dn == '0) && !r_endp;
    assign cur_done = r_phup ? up_done : dn_done;
    assign seek_sum = {1'b0, r_seek} + (SEEK_BITS + 1)'(alu.mag);
    assign seek_nx  = seek_sum[SEEK_BITS] ? '1 : seek_sum[SEEK_BITS-1:0];

    // top track, clamped to the track range
    always_comb begin
        if (r_disk_tracks == '0) begin
            endt = '0;
        end else if (r_disk_tracks[TRACKS_BITS-1]) begin
            endt = '1;
        end else begin
            endt = r_disk_tracks[TRACK_BITS-1:0] - t_track'(1);
        end
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_res.valid        = r_ovld;
    assign o_res.served_track = r_otrk;
    assign o_res.total_seek   = r_oseek;
    assign o_res.last_result  = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (r_count != CW'(MAX_REQUESTS)) begin
                        n_state = ST_INS;
                    end else if (i_req.last_request) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_INS: begin
                if (!((r_j != '0) && alu.neg)) begin
                    n_state = r_lastq ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                if (r_rem == '0) begin
                    n_state = ST_IDLE;
                end else if (!cur_done) begin
                    n_state = ST_EM_SEL;
                end
            end
            ST_EM_SEL: n_state = ST_EM_MOV;
            ST_EM_MOV: begin
                if (out_free) begin
                    n_state = ST_EM_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and register next values
    always_comb begin
        n_count   = r_count;
        n_j       = r_j;
        n_t       = r_t;
        n_lastq   = r_lastq;
        n_head    = r_head;
        n_idx     = r_idx;
        n_cntl    = r_cntl;
        n_cnte    = r_cnte;
        n_dn      = r_dn;
        n_up      = r_up;
        n_rem     = r_rem;
        n_endp    = r_endp;
        n_phup    = r_phup;
        n_trk     = r_trk;
        n_seek    = r_seek;
        n_ovld    = r_ovld && !o_res.ready;
        n_otrk    = r_otrk;
        n_oseek   = r_oseek;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_j[IW-1:0];
        ram_wdata = r_t;
        ram_raddr = '0;
        alu_a     = r_t;
        alu_b     = ram_rdata;

        unique case (r_state)
            ST_IDLE: begin
                ram_raddr = cnt_m1[IW-1:0];
                if (acc) begin
                    n_t     = i_req.request_track;
                    n_j     = r_count;
                    n_lastq = i_req.last_request;
                    n_idx   = '0;
                    n_cntl  = '0;
                    n_cnte  = '0;
                    if (i_req.last_request) begin
                        n_head = r_start_head;
                    end
                end
            end
            ST_INS: begin
                ram_we = 1'b1;
                if ((r_j != '0) && alu.neg) begin
                    // stored entry is larger: move it up one slot
                    ram_wdata = ram_rdata;
                    n_j       = r_j - CW'(1);
                    ram_raddr = j_m2[IW-1:0];
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ST_SCAN: begin
                ram_raddr = r_idx[IW-1:0];
                alu_a     = ram_rdata;
                alu_b     = r_head;
                if (r_idx != '0) begin
                    n_cntl = r_cntl + CW'(alu.neg);
                    n_cnte = r_cnte + CW'(alu.neg || alu.zero);
                end
                if (r_idx == r_count) begin
                    n_dn   = n_cntl;
                    n_up   = n_cnte;
                    n_rem  = RW'(n_cntl) + RW'(r_count - n_cnte) + RW'(1);
                    n_endp = 1'b1;
                    n_phup = r_dir;
                    n_seek = '0;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_EM_RD: begin
                ram_raddr = r_phup ? r_up[IW-1:0] : dn_m1[IW-1:0];
                if (r_rem == '0) begin
                    n_count = '0;
                end else if (cur_done) begin
                    n_phup = !r_phup;
                end
            end
            ST_EM_SEL: begin
                alu_a = endt;
                alu_b = ram_rdata;
                if (!r_phup) begin
                    if (r_dn != '0) begin
                        n_trk = ram_rdata;
                        n_dn  = dn_m1;
                    end else begin
                        n_trk  = '0;
                        n_endp = 1'b0;
                    end
                end else begin
                    // merge the top track into the ascending walk
                    if ((r_up != r_count) && (!r_endp || !alu.neg)) begin
                        n_trk = ram_rdata;
                        n_up  = r_up + CW'(1);
                    end else begin
                        n_trk  = endt;
                        n_endp = 1'b0;
                    end
                end
            end
            ST_EM_MOV: begin
                alu_a = r_trk;
                alu_b = r_head;
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_otrk  = r_trk;
                    n_oseek = seek_nx;
                    n_olast = (r_rem == RW'(1));
                    n_seek  = seek_nx;
                    n_head  = r_trk;
                    n_rem   = r_rem - RW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_ovld        <= 1'b0;
            r_disk_tracks <= DISK_TRACKS_RST;
            r_dir         <= 1'b0;
            r_start_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DISK_TRACKS: r_disk_tracks <= i_cfg_wdata;
                    CFG_START_DIR:   r_dir         <= i_cfg_wdata[0];
                    CFG_START_HEAD:  r_start_head  <= i_cfg_wdata[TRACK_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_t     <= n_t;
        r_lastq <= n_lastq;
        r_head  <= n_head;
        r_idx   <= n_idx;
        r_cntl  <= n_cntl;
        r_cnte  <= n_cnte;
        r_dn    <= n_dn;
        r_up    <= n_up;
        r_rem   <= n_rem;
        r_endp  <= n_endp;
        r_phup  <= n_phup;
        r_trk   <= n_trk;
        r_seek  <= n_seek;
        r_otrk  <= n_otrk;
        r_oseek <= n_oseek;
        r_olast <= n_olast;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REQUESTS))
        else $error("request count above store depth");

    a_move_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_MOV) |-> (r_rem != '0))
        else $error("track served with no result left");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_RD && up_done && dn_done) |-> (r_rem == '0))
        else $error("both sweeps done with results left");
`endif
endmodule

// File: rtl/sds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sds_alu.sv
// Shared track subtractor: sign, equality and magnitude of a minus b.
module sds_alu (
    input  sds_pkg::t_track   i_a,
    input  sds_pkg::t_track   i_b,
    output sds_pkg::t_alu_res o_res
);
    import sds_pkg::*;

    logic [TRACK_BITS:0] diff;

    assign diff       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.neg  = diff[TRACK_BITS];
    assign o_res.zero = (diff == '0);
    assign o_res.mag  = diff[TRACK_BITS] ? (~diff[TRACK_BITS-1:0] + t_track'(1))
                                         : diff[TRACK_BITS-1:0];
endmodule
